// ===== sv/pfm_pkg.sv =====
// Shared constants and types for the three-channel flow meter.
`timescale 1ns / 1ps
`default_nettype none

package pfm_pkg;

  localparam int CHANNELS     = 3;
  localparam int COUNT_BITS   = 16;
  localparam int ELAPSED_BITS = 17;
  localparam int WINDOW_BITS  = 16;
  localparam int CAL_BITS     = 8;
  localparam int RATE_BITS    = 16;
  localparam int VOL_BITS     = 21;
  localparam int TOTAL_BITS   = 48;

  // Configuration port.
  localparam int CFG_IDX_BITS  = 2;
  localparam int CFG_DATA_BITS = 16;
  localparam logic [CFG_IDX_BITS-1:0] REG_WINDOW = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_CAL    = 2'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_LIMIT  = 2'd2;

  localparam logic [WINDOW_BITS-1:0] WINDOW_RESET = 16'd1000;
  localparam logic [CAL_BITS-1:0]    CAL_RESET    = 8'd80;
  localparam logic [RATE_BITS-1:0]   LIMIT_RESET  = 16'd2816;

  // 1000 ms/s, 16 to drop the Q4.4 fraction of the calibration, 256 for Q8.8.
  localparam int SCALE_BITS = 22;
  localparam logic [SCALE_BITS-1:0] RATE_SCALE = 22'd4096000;

  localparam int NUM_BITS = COUNT_BITS + SCALE_BITS;
  localparam int DEN_BITS = ELAPSED_BITS + CAL_BITS;
  localparam int DIV_BITS = (NUM_BITS > DEN_BITS + RATE_BITS) ? NUM_BITS
                                                              : DEN_BITS + RATE_BITS;
  localparam int QIDX_BITS = $clog2(RATE_BITS);

  // rate*1000/60 is rate*50/3; the divide by three is a reciprocal multiply.
  localparam int Y_BITS = 22;
  localparam logic [Y_BITS-1:0] VOL_MUL = 22'd50;
  localparam int RECIP_BITS  = 22;
  localparam int RECIP_SHIFT = 23;
  localparam logic [RECIP_BITS-1:0] RECIP_3 = 22'd2796203;
  localparam int PROD_BITS = Y_BITS + RECIP_BITS;

  typedef struct packed {
    logic                  done;
    logic [RATE_BITS-1:0]  rate;
    logic [VOL_BITS-1:0]   vol;
    logic [TOTAL_BITS-1:0] tot;
  } lane_res_t;

endpackage

`default_nettype wire

// ===== sv/pfm_lane.sv =====
// One channel: rate division, glitch filter, volume and running total.
`timescale 1ns / 1ps
`default_nettype none

module pfm_lane (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               start,
  input  wire logic [pfm_pkg::COUNT_BITS-1:0]     count,
  input  wire logic [pfm_pkg::ELAPSED_BITS-1:0]   elapsed,
  input  wire logic [pfm_pkg::CAL_BITS-1:0]       cal,
  input  wire logic [pfm_pkg::RATE_BITS-1:0]      rate_limit,
  input  wire logic                               commit,
  output pfm_pkg::lane_res_t                      res
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_MUL  = 3'd1;
  localparam logic [2:0] S_CHK  = 3'd2;
  localparam logic [2:0] S_DIV  = 3'd3;
  localparam logic [2:0] S_LIM  = 3'd4;
  localparam logic [2:0] S_VOL  = 3'd5;
  localparam logic [2:0] S_TOT  = 3'd6;
  localparam logic [2:0] S_DONE = 3'd7;

  logic [2:0]                        state;
  logic [pfm_pkg::COUNT_BITS-1:0]    cnt_r;
  logic [pfm_pkg::ELAPSED_BITS-1:0]  el_r;
  logic [pfm_pkg::NUM_BITS-1:0]      num;
  logic [pfm_pkg::DEN_BITS-1:0]      den;
  logic [pfm_pkg::NUM_BITS-1:0]      rem;
  logic [pfm_pkg::DIV_BITS-1:0]      dsh;
  logic [pfm_pkg::QIDX_BITS-1:0]     bit_idx;
  logic [pfm_pkg::RATE_BITS-1:0]     quo;
  logic [pfm_pkg::RATE_BITS-1:0]     rate_r;
  logic [pfm_pkg::Y_BITS-1:0]        y;
  logic [pfm_pkg::VOL_BITS-1:0]      vol;
  logic [pfm_pkg::TOTAL_BITS-1:0]    tot;
  logic [pfm_pkg::RATE_BITS-1:0]     last_rate;
  logic [pfm_pkg::TOTAL_BITS-1:0]    total;

  logic [pfm_pkg::DIV_BITS-1:0]      den_top;
  logic [pfm_pkg::DIV_BITS-1:0]      rem_w;
  logic [pfm_pkg::RATE_BITS-1:0]     rate_sel;
  logic [pfm_pkg::PROD_BITS-1:0]     prod;
  logic [pfm_pkg::TOTAL_BITS:0]      sum;

  always_comb begin
    den_top  = pfm_pkg::DIV_BITS'(den) << pfm_pkg::RATE_BITS;
    rem_w    = pfm_pkg::DIV_BITS'(rem);
    rate_sel = (quo >= rate_limit) ? last_rate : quo;
    prod     = pfm_pkg::PROD_BITS'(y) * pfm_pkg::PROD_BITS'(pfm_pkg::RECIP_3);
    sum      = {1'b0, total} + (pfm_pkg::TOTAL_BITS + 1)'(vol);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      last_rate <= '0;
      total     <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (start) begin
            cnt_r <= count;
            el_r  <= elapsed;
            state <= S_MUL;
          end
        end
        S_MUL: begin
          num   <= pfm_pkg::NUM_BITS'(cnt_r) * pfm_pkg::NUM_BITS'(pfm_pkg::RATE_SCALE);
          den   <= pfm_pkg::DEN_BITS'(el_r) * pfm_pkg::DEN_BITS'(cal);
          state <= S_CHK;
        end
        S_CHK: begin
          // A zero divisor or a quotient that would not fit in 16 bits saturates straight away.
          if (den == '0 || pfm_pkg::DIV_BITS'(num) >= den_top) begin
            quo   <= '1;
            state <= S_LIM;
          end else begin
            rem     <= num;
            dsh     <= pfm_pkg::DIV_BITS'(den) << (pfm_pkg::RATE_BITS - 1);
            bit_idx <= '1;
            quo     <= '0;
            state   <= S_DIV;
          end
        end
        S_DIV: begin
          if (rem_w >= dsh) begin
            rem          <= pfm_pkg::NUM_BITS'(rem_w - dsh);
            quo[bit_idx] <= 1'b1;
          end
          dsh     <= dsh >> 1;
          bit_idx <= bit_idx - 1'b1;
          if (bit_idx == '0) begin
            state <= S_LIM;
          end
        end
        S_LIM: begin
          rate_r <= rate_sel;
          y      <= pfm_pkg::Y_BITS'(rate_sel) * pfm_pkg::VOL_MUL;
          state  <= S_VOL;
        end
        S_VOL: begin
          vol   <= pfm_pkg::VOL_BITS'(prod >> pfm_pkg::RECIP_SHIFT);
          state <= S_TOT;
        end
        S_TOT: begin
          tot   <= sum[pfm_pkg::TOTAL_BITS] ? '1 : sum[pfm_pkg::TOTAL_BITS-1:0];
          state <= S_DONE;
        end
        S_DONE: begin
          if (commit) begin
            last_rate <= rate_r;
            total     <= tot;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_comb begin
    res.done = (state == S_DONE);
    res.rate = rate_r;
    res.vol  = vol;
    res.tot  = tot;
  end

endmodule

`default_nettype wire

// ===== sv/pfm_merge.sv =====
// Merging stage: waits for every lane and loads the shared output register.
`timescale 1ns / 1ps
`default_nettype none

module pfm_merge (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire pfm_pkg::lane_res_t                res [pfm_pkg::CHANNELS],
  input  wire logic                              out_ready,
  output logic                                   commit,
  output logic                                   out_valid,
  output logic [pfm_pkg::RATE_BITS-1:0]          rate [pfm_pkg::CHANNELS],
  output logic [pfm_pkg::VOL_BITS-1:0]           vol [pfm_pkg::CHANNELS],
  output logic [pfm_pkg::TOTAL_BITS-1:0]         tot [pfm_pkg::CHANNELS]
);

  logic all_done;

  always_comb begin
    all_done = 1'b1;
    for (int i = 0; i < pfm_pkg::CHANNELS; i++) begin
      all_done = all_done & res[i].done;
    end
    // The report moves only when the output slot is free or being emptied.
    commit = all_done && (!out_valid || out_ready);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (commit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      for (int i = 0; i < pfm_pkg::CHANNELS; i++) begin
        rate[i] <= res[i].rate;
        vol[i]  <= res[i].vol;
        tot[i]  <= res[i].tot;
      end
    end
  end

endmodule

`default_nettype wire

// ===== sv/pulse_flow_meter_three_channel.sv =====
// Top level of the three-channel flow meter: counters, configuration, lanes, merge.
`timescale 1ns / 1ps
`default_nettype none

// Counts sensor pulses and millisecond ticks one transaction per cycle. When the
// elapsed tick count passes window_ms, the transaction that crossed it starts a
// report: each of the three lanes divides its pulse count by elapsed*cal_factor
// with a shift-subtract divider that yields one quotient bit per cycle, so the
// input stays stalled through the multiply, range check, 16 divide steps,
// glitch filter, volume, total and the handoff to the output register (the
// divide steps are skipped when every lane's rate saturates at the range
// check), plus any wait for the output register to empty.
// Between reports every input transaction is taken without a stall, also while a
// finished report still waits on the output. Configuration is written with
// cfg_write, cfg_index and cfg_data.
module pulse_flow_meter_three_channel (
  input  wire logic                                   clk,
  input  wire logic                                   rst,
  input  wire logic                                   cfg_write,
  input  wire logic [pfm_pkg::CFG_IDX_BITS-1:0]       cfg_index,
  input  wire logic [pfm_pkg::CFG_DATA_BITS-1:0]      cfg_data,
  input  wire logic                                   in_valid,
  output logic                                        in_ready,
  input  wire logic                                   tick,
  input  wire logic                                   pulse_a,
  input  wire logic                                   pulse_b,
  input  wire logic                                   pulse_c,
  output logic                                        out_valid,
  input  wire logic                                   out_ready,
  output logic [pfm_pkg::RATE_BITS-1:0]               rate_a,
  output logic [pfm_pkg::RATE_BITS-1:0]               rate_b,
  output logic [pfm_pkg::RATE_BITS-1:0]               rate_c,
  output logic [pfm_pkg::VOL_BITS-1:0]                volume_a,
  output logic [pfm_pkg::VOL_BITS-1:0]                volume_b,
  output logic [pfm_pkg::VOL_BITS-1:0]                volume_c,
  output logic [pfm_pkg::TOTAL_BITS-1:0]              total_a,
  output logic [pfm_pkg::TOTAL_BITS-1:0]              total_b,
  output logic [pfm_pkg::TOTAL_BITS-1:0]              total_c
);

  logic [pfm_pkg::WINDOW_BITS-1:0]  window_ms;
  logic [pfm_pkg::CAL_BITS-1:0]     cal_factor;
  logic [pfm_pkg::RATE_BITS-1:0]    rate_limit;

  logic [pfm_pkg::COUNT_BITS-1:0]   counts      [pfm_pkg::CHANNELS];
  logic [pfm_pkg::COUNT_BITS-1:0]   counts_next [pfm_pkg::CHANNELS];
  logic [pfm_pkg::ELAPSED_BITS-1:0] elapsed;
  logic [pfm_pkg::ELAPSED_BITS-1:0] elapsed_next;
  logic                             busy;

  logic [pfm_pkg::CHANNELS-1:0]     pulses;
  logic                             accept;
  logic                             report;
  logic                             commit;

  pfm_pkg::lane_res_t               res  [pfm_pkg::CHANNELS];
  logic [pfm_pkg::RATE_BITS-1:0]    rate [pfm_pkg::CHANNELS];
  logic [pfm_pkg::VOL_BITS-1:0]     vol  [pfm_pkg::CHANNELS];
  logic [pfm_pkg::TOTAL_BITS-1:0]   tot  [pfm_pkg::CHANNELS];

  always_ff @(posedge clk) begin
    if (rst) begin
      window_ms  <= pfm_pkg::WINDOW_RESET;
      cal_factor <= pfm_pkg::CAL_RESET;
      rate_limit <= pfm_pkg::LIMIT_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        pfm_pkg::REG_WINDOW: window_ms  <= pfm_pkg::WINDOW_BITS'(cfg_data);
        pfm_pkg::REG_CAL:    cal_factor <= pfm_pkg::CAL_BITS'(cfg_data);
        pfm_pkg::REG_LIMIT:  rate_limit <= pfm_pkg::RATE_BITS'(cfg_data);
        default: ;
      endcase
    end
  end

  assign pulses   = {pulse_c, pulse_b, pulse_a};
  assign in_ready = !busy;
  assign accept   = in_valid && in_ready;

  always_comb begin
    for (int i = 0; i < pfm_pkg::CHANNELS; i++) begin
      counts_next[i] = (pulses[i] && counts[i] != '1) ? counts[i] + 1'b1 : counts[i];
    end
    elapsed_next = (tick && elapsed != '1) ? elapsed + 1'b1 : elapsed;
    report       = accept && (elapsed_next > pfm_pkg::ELAPSED_BITS'(window_ms));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      elapsed <= '0;
      busy    <= 1'b0;
      for (int i = 0; i < pfm_pkg::CHANNELS; i++) begin
        counts[i] <= '0;
      end
    end else begin
      if (report) begin
        elapsed <= '0;
        busy    <= 1'b1;
        for (int i = 0; i < pfm_pkg::CHANNELS; i++) begin
          counts[i] <= '0;
        end
      end else if (accept) begin
        elapsed <= elapsed_next;
        for (int i = 0; i < pfm_pkg::CHANNELS; i++) begin
          counts[i] <= counts_next[i];
        end
      end else if (commit) begin
        busy <= 1'b0;
      end
    end
  end

  for (genvar g = 0; g < pfm_pkg::CHANNELS; g++) begin : g_lane
    pfm_lane u_lane (
      .clk        (clk),
      .rst        (rst),
      .start      (report),
      .count      (counts_next[g]),
      .elapsed    (elapsed_next),
      .cal        (cal_factor),
      .rate_limit (rate_limit),
      .commit     (commit),
      .res        (res[g])
    );
  end

  pfm_merge u_merge (
    .clk       (clk),
    .rst       (rst),
    .res       (res),
    .out_ready (out_ready),
    .commit    (commit),
    .out_valid (out_valid),
    .rate      (rate),
    .vol       (vol),
    .tot       (tot)
  );

  assign rate_a   = rate[0];
  assign rate_b   = rate[1];
  assign rate_c   = rate[2];
  assign volume_a = vol[0];
  assign volume_b = vol[1];
  assign volume_c = vol[2];
  assign total_a  = tot[0];
  assign total_b  = tot[1];
  assign total_c  = tot[2];

endmodule

`default_nettype wire
